@@ hw/rtl/integer_to_ascii_radix_defines.svh @@
// Assertion macros used by itoar_ctrl in the integer_to_ascii_radix RTL.
// Macros expect signals named clk and rst in the scope where they are used.
`ifndef INTEGER_TO_ASCII_RADIX_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_DEFINES_SVH

// Check cons in the same cycle as ante.
`define ITOAR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("itoar assertion failed");

// Check cons in the cycle after ante.
`define ITOAR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("itoar assertion failed");

`endif

@@ hw/rtl/itoar_pkg.sv @@
// Shared types, constants and helpers for the integer_to_ascii_radix block.
// No dependencies.
`default_nettype none

package itoar_pkg;

  localparam int VALUE_WIDTH = 31;
  localparam int DIGIT_W     = 4;
  localparam int NDEC        = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int NHEX        = (VALUE_WIDTH + 3) / 4;
  localparam int NCELL       = (NDEC > NHEX) ? NDEC : NHEX;
  localparam int COUNT_W     = $clog2(VALUE_WIDTH + 1);

  localparam logic [1:0] OP_BIN = 2'd0;
  localparam logic [1:0] OP_DEC = 2'd1;

  localparam logic [6:0] ASCII_ZERO = 7'h30;
  localparam logic [6:0] ASCII_A    = 7'h41;
  localparam logic [6:0] TEN        = 7'd10;

  typedef struct packed {
    logic [1:0]             op;
    logic [VALUE_WIDTH-1:0] value;
  } request_t;

  typedef struct packed {
    logic [6:0] digit_char;
    logic       last;
  } result_t;

  typedef struct packed {
    logic load;
    logic dabble;
    logic advance;
  } cell_ctl_t;

  typedef logic [NCELL-1:0][DIGIT_W-1:0] digit_vec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  function automatic logic [6:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [6:0] wide;
    wide = {{(7 - DIGIT_W){1'b0}}, d};
    return (d < DIGIT_W'(10)) ? ASCII_ZERO + wide : ASCII_A + wide - TEN;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/itoar_cell.sv @@
// One digit cell of the conversion chain: shift-add-3 step, parallel load,
// and shift toward the top during output. Depends on itoar_pkg.
`default_nettype none

module itoar_cell (
  input  logic                          clk,
  input  itoar_pkg::cell_ctl_t          ctl,
  input  logic [itoar_pkg::DIGIT_W-1:0] load_digit,
  input  logic                          carry_in,
  input  logic [itoar_pkg::DIGIT_W-1:0] lower_digit,
  output logic                          carry_out,
  output logic [itoar_pkg::DIGIT_W-1:0] digit
);
  import itoar_pkg::*;

  logic [DIGIT_W-1:0] adjusted;
  logic [DIGIT_W-1:0] digit_next;

  always_comb begin
    adjusted  = (digit >= DIGIT_W'(5)) ? digit + DIGIT_W'(3) : digit;
    carry_out = adjusted[DIGIT_W-1];
    priority if (ctl.load) begin
      digit_next = load_digit;
    end else if (ctl.dabble) begin
      digit_next = {adjusted[DIGIT_W-2:0], carry_in};
    end else if (ctl.advance) begin
      digit_next = lower_digit;
    end else begin
      digit_next = digit;
    end
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

endmodule

`default_nettype wire

@@ hw/rtl/itoar_ctrl.sv @@
// Sequencer of the conversion: request capture, bit feed into the cell chain,
// digit selection and the registered result. Depends on itoar_pkg and the defines.
`default_nettype none
`include "integer_to_ascii_radix_defines.svh"

module itoar_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  itoar_pkg::request_t           request,
  output logic                          busy,
  output logic                          strobe,
  output itoar_pkg::result_t            result,
  output itoar_pkg::cell_ctl_t          ctl,
  output itoar_pkg::digit_vec_t         load_digits,
  output logic                          feed_bit,
  input  logic [itoar_pkg::DIGIT_W-1:0] top_digit
);
  import itoar_pkg::*;

  localparam logic [COUNT_W-1:0] COUNT_VALUE = COUNT_W'(VALUE_WIDTH);
  localparam logic [COUNT_W-1:0] COUNT_CELLS = COUNT_W'(NCELL);
  localparam logic [COUNT_W-1:0] COUNT_ONE   = COUNT_W'(1);

  state_t                   state;
  state_t                   state_next;
  logic [COUNT_W-1:0]       count;
  logic [COUNT_W-1:0]       count_next;
  logic                     started;
  logic                     started_next;
  logic [1:0]               op_sel;
  logic [VALUE_WIDTH-1:0]   shreg;
  logic [NCELL*DIGIT_W-1:0] wide_value;
  logic [DIGIT_W-1:0]       emit_digit;
  logic                     emit_now;
  logic                     take;

  assign busy       = (state != ST_IDLE);
  assign take       = (state == ST_IDLE) && start;
  assign feed_bit   = shreg[VALUE_WIDTH-1];
  assign emit_digit = (op_sel == OP_BIN) ? {{(DIGIT_W - 1){1'b0}}, shreg[VALUE_WIDTH-1]}
                                         : top_digit;
  assign emit_now   = (state == ST_EMIT) &&
                      (started || (emit_digit != '0) || (count == COUNT_ONE));

  always_comb begin
    wide_value = '0;
    wide_value[VALUE_WIDTH-1:0] = request.value;
  end

  // next state
  always_comb begin
    state_next   = state;
    count_next   = count;
    started_next = started;
    unique case (state)
      ST_IDLE: begin
        started_next = 1'b0;
        if (start) begin
          unique case (request.op)
            OP_BIN: begin
              state_next = ST_EMIT;
              count_next = COUNT_VALUE;
            end
            OP_DEC: begin
              state_next = ST_CONV;
              count_next = COUNT_VALUE;
            end
            default: begin
              state_next = ST_EMIT;
              count_next = COUNT_CELLS;
            end
          endcase
        end
      end
      ST_CONV: begin
        count_next = count - COUNT_ONE;
        if (count == COUNT_ONE) begin
          state_next = ST_EMIT;
          count_next = COUNT_CELLS;
        end
      end
      ST_EMIT: begin
        count_next   = count - COUNT_ONE;
        started_next = started | emit_now;
        if (count == COUNT_ONE) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // cell chain control
  always_comb begin
    ctl         = '0;
    load_digits = '0;
    unique case (state)
      ST_IDLE: begin
        ctl.load = start;
        if (request.op != OP_BIN && request.op != OP_DEC) begin
          load_digits = digit_vec_t'(wide_value);
        end
      end
      ST_CONV: ctl.dabble  = 1'b1;
      ST_EMIT: ctl.advance = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      started <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      started <= started_next;
      strobe  <= emit_now;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op_sel <= request.op;
      shreg  <= request.value;
    end else if (busy) begin
      shreg <= shreg << 1;
    end
    if (emit_now) begin
      result.digit_char <= digit_to_ascii(emit_digit);
      result.last       <= (count == COUNT_ONE);
    end
  end

  `ITOAR_ASSERT_NEXT(a_take_busy, take, busy)
  `ITOAR_ASSERT_NOW(a_busy_count, busy, count != '0)
  `ITOAR_ASSERT_NEXT(a_final_digit, (state == ST_EMIT) && (count == COUNT_ONE),
                     strobe && result.last && !busy)
  `ITOAR_ASSERT_NOW(a_mid_digit, strobe && !result.last, busy)

endmodule

`default_nettype wire

@@ hw/rtl/integer_to_ascii_radix.sv @@
// Top level of the integer to ASCII converter: sequencer plus digit cell chain.
// Depends on itoar_pkg, itoar_cell and itoar_ctrl.
//
// Usage:
//   Drive request (op, value) and raise start while busy is low; the request
//   is taken at that clock edge. op selects binary, decimal or upper-case hex
//   (the unused code renders hex). Characters come out most significant first,
//   one per cycle while emitting, each shown for exactly one cycle with strobe
//   high; result.last marks the final character. Leading zeros are dropped,
//   and zero renders as a single '0'.
// Conversion (10 digit cells for 31 bits):
//   binary and hex requests go straight to output; decimal requests first run
//   the shift-add-3 pass, one value bit a cycle through the cell chain,
//   followed by one cell shift per digit cell during output.
// The first character appears in the cycle after the scan reaches it.
// Reset: synchronous rst returns the block to idle with no strobe pending.
// The receiver cannot stall: every strobed character must be taken as shown.
`default_nettype none

module integer_to_ascii_radix (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  itoar_pkg::request_t request,
  output logic                busy,
  output logic                strobe,
  output itoar_pkg::result_t  result
);
  import itoar_pkg::*;

  cell_ctl_t          ctl;
  digit_vec_t         load_digits;
  digit_vec_t         digits;
  logic [NCELL-1:0]   carry;
  logic               feed_bit;

  itoar_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .request     (request),
    .busy        (busy),
    .strobe      (strobe),
    .result      (result),
    .ctl         (ctl),
    .load_digits (load_digits),
    .feed_bit    (feed_bit),
    .top_digit   (digits[NCELL-1])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    if (i == 0) begin : g_first
      itoar_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .load_digit  (load_digits[i]),
        .carry_in    (feed_bit),
        .lower_digit ('0),
        .carry_out   (carry[i]),
        .digit       (digits[i])
      );
    end else begin : g_rest
      itoar_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .load_digit  (load_digits[i]),
        .carry_in    (carry[i-1]),
        .lower_digit (digits[i-1]),
        .carry_out   (carry[i]),
        .digit       (digits[i])
      );
    end
  end

endmodule

`default_nettype wire

@@ bench/tb_integer_to_ascii_radix.sv @@
// Testbench for integer_to_ascii_radix: drives binary, decimal and hex requests and checks
// every strobed character against a built-in digit predictor held in a small scoreboard.
// Depends on itoar_pkg and the integer_to_ascii_radix RTL.
`default_nettype none

module tb_integer_to_ascii_radix;
  timeunit 1ns;
  timeprecision 1ps;

  import itoar_pkg::*;

  localparam logic [1:0] OP_HEX = 2'd2;
  localparam logic [1:0] OP_ALT = 2'd3;
  localparam int RANDOM_REQUESTS = 207;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_PRINTED = 200;

  class char_scoreboard;
    result_t pending_chars[$];
    int mismatches = 0;

    function automatic void note_request(request_t req);
      result_t digits[$];
      result_t ch;
      logic [VALUE_WIDTH-1:0] rest;
      logic [3:0] d;
      rest = req.value;
      do begin
        case (req.op)
          OP_BIN: begin
            d = 4'(rest[0]);
            rest = rest >> 1;
          end
          OP_DEC: begin
            d = 4'(rest % 10);
            rest = rest / 10;
          end
          default: begin
            d = rest[3:0];
            rest = rest >> 4;
          end
        endcase
        ch.digit_char = (d < 4'd10) ? 7'(ASCII_ZERO + d) : 7'(ASCII_A + d - 4'd10);
        ch.last = 1'b0;
        digits.push_front(ch);
      end while (rest != '0);
      digits[digits.size() - 1].last = 1'b1;
      foreach (digits[i]) pending_chars.push_back(digits[i]);
    endfunction

    task report(string msg);
      if (mismatches < MAX_PRINTED) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_char(result_t got);
      result_t want;
      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected character 0x%02h last=%0b", got.digit_char, got.last));
      end else begin
        want = pending_chars.pop_front();
        if (got.digit_char !== want.digit_char)
          report($sformatf("digit_char 0x%02h, expected 0x%02h",
                           got.digit_char, want.digit_char));
        if (got.last !== want.last)
          report($sformatf("last %0b, expected %0b on char 0x%02h",
                           got.last, want.last, want.digit_char));
      end
    endtask

    function int pending_count();
      return pending_chars.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start;
  request_t request;
  logic busy;
  logic strobe;
  result_t result;

  char_scoreboard sb;
  int cycle_count = 0;
  logic [1:0] op_codes[4] = '{OP_BIN, OP_DEC, OP_HEX, OP_ALT};
  logic [VALUE_WIDTH-1:0] boundary_vals[3] = '{'0, VALUE_WIDTH'(1), '1};

  integer_to_ascii_radix dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_integer_to_ascii_radix: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && strobe) sb.check_char(result);
  end

  task automatic send_request(logic [1:0] op, logic [VALUE_WIDTH-1:0] value);
    @(negedge clk);
    start <= 1'b1;
    request <= '{op: op, value: value};
    do @(posedge clk); while (busy);
    sb.note_request(request);
  endtask

  task automatic hold_off(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start <= 1'b0;
      request <= {2'($urandom), 31'($urandom)};
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain_pending();
    hold_off(1);
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  function automatic int pick_gap(bit idle_on);
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on) return 0;
    if (r < 60) return $urandom_range(0, 2);
    if (r < 90) return $urandom_range(3, 8);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    int len;
    logic [31:0] raw;
    len = $urandom_range(0, VALUE_WIDTH);
    raw = $urandom;
    if ($urandom_range(0, 4) == 0) return raw[VALUE_WIDTH-1:0];
    if (len == 0) return '0;
    raw = (raw & ((32'd1 << len) - 1)) | (32'd1 << (len - 1));
    return raw[VALUE_WIDTH-1:0];
  endfunction

  initial begin
    bit idle_on;
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (op_codes[o])
      foreach (boundary_vals[v]) begin
        send_request(op_codes[o], boundary_vals[v]);
        hold_off($urandom_range(0, 1));
      end
    send_request(OP_DEC, VALUE_WIDTH'(9));
    send_request(OP_DEC, VALUE_WIDTH'(10));
    send_request(OP_DEC, VALUE_WIDTH'(1000000000));
    send_request(OP_DEC, VALUE_WIDTH'(1999999999));
    send_request(OP_HEX, VALUE_WIDTH'(15));
    send_request(OP_HEX, VALUE_WIDTH'(16));
    send_request(OP_HEX, 31'h2AAA_AAAA);
    send_request(OP_HEX, 31'h1234_5678);
    send_request(OP_BIN, VALUE_WIDTH'(2));
    send_request(OP_BIN, 31'h5555_5555);
    send_request(OP_ALT, 31'h7ABC_DEF0);
    drain_pending();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 20 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (n == RANDOM_REQUESTS / 2) drain_pending();
      send_request(op_codes[$urandom_range(0, 3)], pick_value());
      hold_off(pick_gap(idle_on));
    end

    drain_pending();
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0)
      $display("tb_integer_to_ascii_radix: PASS");
    else
      $display("tb_integer_to_ascii_radix: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
